// File: hw/rtl/echo_window_average_with_rejection_macros.svh
// Assertion macros shared by the echo window averaging RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ECHO_WINDOW_AVERAGE_WITH_REJECTION_MACROS_SVH
`define ECHO_WINDOW_AVERAGE_WITH_REJECTION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EWAR_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("ewar assertion failed");

// Next-cycle implication, checked outside reset.
`define EWAR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("ewar assertion failed");

`endif

// File: hw/rtl/ewar_pkg.sv
// Package for the echo window averaging block: sizes, register indexes,
// verdict codes and the configuration and divider status structs. No dependencies.
package ewar_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_MAX   = 1023;

  localparam int SENSOR_W = 2;
  localparam int ECHO_W   = 16;
  localparam int MEAN_W   = 16;
  localparam int SUM_W    = 27;
  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = $clog2(WINDOW_MAX + 1);
  localparam int PCT_W    = 7;
  localparam int MISS_W   = 8;
  localparam int PROD_W   = MEAN_W + PCT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_SENSOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_SET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_MULT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_PCT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_PCT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 3'd6;

  localparam logic [1:0] VERDICT_REJECT = 2'd0;
  localparam logic [1:0] VERDICT_WITHIN = 2'd1;
  localparam logic [1:0] VERDICT_FORCED = 2'd2;
  localparam logic [1:0] VERDICT_FIRST  = 2'd3;

  typedef struct packed {
    logic [SENSOR_W-1:0] ref_sensor;
    logic [LIMIT_W-1:0]  ref_limit;
    logic [LIMIT_W-1:0]  sens_limit;
    logic [PCT_W-1:0]    ref_pct;
    logic [PCT_W-1:0]    sens_pct;
    logic [MISS_W-1:0]   miss_limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/ewar_cfg.sv
// Configuration registers of the echo window averaging block and the
// clamped window limits derived from them. Depends on ewar_pkg.
module ewar_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ewar_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ewar_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output ewar_pkg::cfg_t                   cfg_o
);

  logic [1:0] ref_sensor_q;
  logic [9:0] ref_window_q;
  logic [7:0] avg_set_q;
  logic [6:0] avg_mult_q;
  logic [6:0] ref_pct_q;
  logic [6:0] sens_pct_q;
  logic [7:0] miss_limit_q;

  logic [14:0] prod;
  logic [15:0] ref_wide;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_sensor_q <= 2'd3;
      ref_window_q <= 10'd16;
      avg_set_q    <= 8'd1;
      avg_mult_q   <= 7'd4;
      ref_pct_q    <= 7'd10;
      sens_pct_q   <= 7'd10;
      miss_limit_q <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ewar_pkg::CFG_REF_SENSOR: ref_sensor_q <= cfg_data_i[1:0];
        ewar_pkg::CFG_REF_WINDOW: ref_window_q <= cfg_data_i[9:0];
        ewar_pkg::CFG_AVG_SET:    avg_set_q    <= cfg_data_i[7:0];
        ewar_pkg::CFG_AVG_MULT:   avg_mult_q   <= cfg_data_i[6:0];
        ewar_pkg::CFG_REF_PCT:    ref_pct_q    <= cfg_data_i[6:0];
        ewar_pkg::CFG_SENS_PCT:   sens_pct_q   <= cfg_data_i[6:0];
        ewar_pkg::CFG_MISS_LIMIT: miss_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign prod     = 15'(avg_set_q) * 15'(avg_mult_q);
  assign ref_wide = 16'(ref_window_q);

  always_comb begin
    cfg_o            = '0;
    cfg_o.ref_sensor = ref_sensor_q;
    cfg_o.ref_pct    = ref_pct_q;
    cfg_o.sens_pct   = sens_pct_q;
    cfg_o.miss_limit = miss_limit_q;
    // Both limits saturate at WINDOW_MAX, the largest value the LIMIT_W-bit fields hold.
    if (32'(prod) > 32'(ewar_pkg::WINDOW_MAX)) begin
      cfg_o.sens_limit = ewar_pkg::LIMIT_W'(ewar_pkg::WINDOW_MAX);
    end else begin
      cfg_o.sens_limit = ewar_pkg::LIMIT_W'(prod);
    end
    if (32'(ref_wide) > 32'(ewar_pkg::WINDOW_MAX)) begin
      cfg_o.ref_limit = ewar_pkg::LIMIT_W'(ewar_pkg::WINDOW_MAX);
    end else begin
      cfg_o.ref_limit = ewar_pkg::LIMIT_W'(ref_wide);
    end
  end

endmodule

// File: hw/rtl/ewar_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, window sum over
// window count. Depends on ewar_pkg.
module ewar_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ewar_pkg::SUM_W-1:0]     dividend_i,
  input  logic [ewar_pkg::COUNT_W-1:0]   divisor_i,
  output ewar_pkg::div_stat_t            stat_o,
  output logic [ewar_pkg::SUM_W-1:0]     quotient_o
);

  localparam int CntW = $clog2(ewar_pkg::SUM_W + 1);

  logic [ewar_pkg::SUM_W-1:0]   shreg_q;
  logic [ewar_pkg::COUNT_W-1:0] rem_q;
  logic [ewar_pkg::COUNT_W-1:0] divisor_q;
  logic [CntW-1:0]              cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [ewar_pkg::COUNT_W:0]   rem_shift;
  logic [ewar_pkg::COUNT_W:0]   rem_sub;
  logic                         qbit;
  logic [ewar_pkg::COUNT_W-1:0] rem_d;

  // The dividend leaves at the top of the shift register while quotient
  // bits enter at the bottom, so after the last step it holds the quotient.
  assign rem_shift = {rem_q, shreg_q[ewar_pkg::SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor_q};
  assign qbit      = (rem_shift >= {1'b0, divisor_q});
  assign rem_d     = qbit ? rem_sub[ewar_pkg::COUNT_W-1:0]
                          : rem_shift[ewar_pkg::COUNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(ewar_pkg::SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q   <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[ewar_pkg::SUM_W-2:0], qbit};
      rem_q   <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = shreg_q;

endmodule

// File: hw/rtl/echo_window_average_with_rejection.sv
// Echo window averaging with outlier rejection. Each accepted word adds one
// echo sample to its sensor's window; after a word that does not finish a
// window the next word is accepted. A word that finishes a window holds off
// new words: the mean comes from a bit-serial divider giving one bit per cycle
// of the 27-bit window sum, then a band check state that waits for the output
// register to be free. A finished result sits there until it is taken.
`include "echo_window_average_with_rejection_macros.svh"

module echo_window_average_with_rejection (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ewar_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ewar_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ewar_pkg::SENSOR_W-1:0]    sensor_i,
  input  logic [ewar_pkg::ECHO_W-1:0]      echo_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ewar_pkg::SENSOR_W-1:0]    done_sensor_o,
  output logic [ewar_pkg::MEAN_W-1:0]      window_mean_o,
  output logic [ewar_pkg::MEAN_W-1:0]      held_average_o,
  output logic [1:0]                       verdict_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  localparam int SumW   = ewar_pkg::SUM_W;
  localparam int CountW = ewar_pkg::COUNT_W;
  localparam int MeanW  = ewar_pkg::MEAN_W;
  localparam int ProdW  = ewar_pkg::PROD_W;
  localparam int MissW  = ewar_pkg::MISS_W;

  ewar_pkg::cfg_t      cfg;
  ewar_pkg::div_stat_t div_stat;
  logic [SumW-1:0]     quotient;

  logic [1:0] state_q, state_d;

  logic [SumW-1:0]   sum_q   [ewar_pkg::SENSOR_COUNT];
  logic [CountW-1:0] count_q [ewar_pkg::SENSOR_COUNT];
  logic [MeanW-1:0]  held_q  [ewar_pkg::SENSOR_COUNT];
  logic [MissW-1:0]  miss_q  [ewar_pkg::SENSOR_COUNT];
  logic [ewar_pkg::SENSOR_COUNT-1:0] first_q;

  logic [ewar_pkg::SENSOR_W-1:0] sel_q;

  logic                       out_valid_q;
  logic [ewar_pkg::SENSOR_W-1:0] out_sensor_q;
  logic [MeanW-1:0]           out_mean_q;
  logic [MeanW-1:0]           out_held_q;
  logic [1:0]                 out_verdict_q;

  logic                       accept;
  logic                       sensor_ok;
  logic [ewar_pkg::SAMPLE_BITS-1:0] sample;
  logic [SumW-1:0]            new_sum;
  logic [CountW-1:0]          new_count;
  logic [ewar_pkg::LIMIT_W-1:0] limit;
  logic                       window_done;
  logic                       div_start;

  logic                       check_ref;
  logic [MeanW-1:0]           mean;
  logic [MeanW-1:0]           held;
  logic [MeanW-1:0]           diff;
  logic [ewar_pkg::PCT_W-1:0] pct;
  logic [ProdW-1:0]           lhs_prod;
  logic [ProdW-1:0]           rhs_prod;
  logic                       out_of_band;
  logic [MissW-1:0]           miss_inc;
  logic [MissW-1:0]           miss_new;
  logic [MeanW-1:0]           held_new;
  logic [1:0]                 verdict;
  logic                       out_free;
  logic                       out_load;

  ewar_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ewar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (new_sum),
    .divisor_i  (new_count),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign sensor_ok  = (int'(sensor_i) < ewar_pkg::SENSOR_COUNT);
  assign sample     = ewar_pkg::SAMPLE_BITS'(echo_time_i);
  assign new_sum    = sum_q[sensor_i] + SumW'(sample);
  assign new_count  = count_q[sensor_i] + CountW'(1);
  assign limit      = (sensor_i == cfg.ref_sensor) ? cfg.ref_limit : cfg.sens_limit;
  assign window_done = (new_count > CountW'(limit));
  assign div_start  = accept && sensor_ok && window_done;

  // Band test on the finished window: 100 * |mean - held| <= held * pct.
  assign check_ref   = (sel_q == cfg.ref_sensor);
  assign mean        = quotient[MeanW-1:0];
  assign held        = held_q[sel_q];
  assign diff        = (mean >= held) ? (mean - held) : (held - mean);
  assign pct         = check_ref ? cfg.ref_pct : cfg.sens_pct;
  assign lhs_prod    = ProdW'(diff) * ProdW'(ewar_pkg::PCT_SCALE);
  assign rhs_prod    = ProdW'(held) * ProdW'(pct);
  assign out_of_band = (lhs_prod > rhs_prod);
  assign miss_inc    = (miss_q[sel_q] == {MissW{1'b1}}) ? miss_q[sel_q]
                                                        : miss_q[sel_q] + MissW'(1);

  always_comb begin
    miss_new = miss_q[sel_q];
    held_new = held;
    verdict  = ewar_pkg::VERDICT_WITHIN;
    if (out_of_band) begin
      if (miss_inc >= cfg.miss_limit) begin
        miss_new = '0;
        held_new = mean;
        verdict  = ewar_pkg::VERDICT_FORCED;
      end else begin
        miss_new = miss_inc;
        verdict  = ewar_pkg::VERDICT_REJECT;
      end
    end else begin
      held_new = mean;
    end
    // The first window of a sensor is always taken, after the miss update.
    if (first_q[sel_q]) begin
      held_new = mean;
      verdict  = ewar_pkg::VERDICT_FIRST;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_CHECK) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (div_start) state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_CHECK;
      ST_CHECK: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= '0;
      first_q <= '1;
      for (int k = 0; k < ewar_pkg::SENSOR_COUNT; k++) begin
        sum_q[k]   <= '0;
        count_q[k] <= '0;
        held_q[k]  <= '0;
        miss_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept && sensor_ok) begin
        if (window_done) begin
          sum_q[sensor_i]   <= '0;
          count_q[sensor_i] <= '0;
          sel_q             <= sensor_i;
        end else begin
          sum_q[sensor_i]   <= new_sum;
          count_q[sensor_i] <= new_count;
        end
      end
      if (out_load) begin
        held_q[sel_q]  <= held_new;
        miss_q[sel_q]  <= miss_new;
        first_q[sel_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sensor_q  <= sel_q;
      out_mean_q    <= mean;
      out_held_q    <= held_new;
      out_verdict_q <= verdict;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign done_sensor_o  = out_sensor_q;
  assign window_mean_o  = out_mean_q;
  assign held_average_o = out_held_q;
  assign verdict_o      = out_verdict_q;

  `EWAR_ASSERT_IMPL(a_ready_div_idle, clk_i, rst_ni, in_ready_o, !div_stat.busy)
  `EWAR_ASSERT_IMPL(a_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV)
  `EWAR_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_o)
  `EWAR_ASSERT_IMPL(a_taken_mean_held, clk_i, rst_ni,
                    out_valid_o && (verdict_o != ewar_pkg::VERDICT_REJECT),
                    window_mean_o == held_average_o)

endmodule
